// ===== rtl/core/gfl_pkg.sv =====
// Shared types, constants and the arctangent table for the GPS fix to local metric core.
// Has no dependencies; every other file of the core imports it.
`timescale 1ns / 1ps
`default_nettype none

package gfl_pkg;

   localparam int CORDIC_STEPS_DEF = 32;
   localparam int QUEUE_DEPTH      = 2;
   localparam int COORD_W          = 32;
   localparam int RADIUS_W         = 23;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

   localparam logic [1:0] KIND_FIX       = 2'd0;
   localparam logic [1:0] KIND_HOME_GIVEN = 2'd1;
   localparam logic [1:0] KIND_HOME_LAST = 2'd2;

   // Angles in units of 5e-8 degree.
   localparam logic signed [34:0] FULL_TURN    = 35'sd7200000000;
   localparam logic signed [34:0] HALF_TURN    = 35'sd3600000000;
   localparam logic signed [34:0] QUARTER_TURN = 35'sd1800000000;
   // The quarter turn is 2^9 times this odd factor.
   localparam logic [23:0] QUARTER_ODD  = 24'd3515625;
   // Floor of 2^53 divided by the odd factor of the quarter turn.
   localparam logic [31:0] QUARTER_RECIP = 32'd2562047788;
   localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
   localparam logic [61:0] ROUND_HALF   = 62'd900000000;
   localparam logic [30:0] Q30_ONE      = 31'd1073741824;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [34:0] MAX_MM       = 35'd21990232555;

   typedef struct packed {
      logic                      fix;
      logic                      changed;
      logic signed [COORD_W-1:0] home_lat;
      logic signed [COORD_W-1:0] home_lon;
      logic signed [COORD_W-1:0] lat;
      logic signed [COORD_W-1:0] lon;
   } gfl_job_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WRAP, ST_FOLD, ST_MUL, ST_DIV, ST_RINIT, ST_ROT, ST_REND,
      ST_PROD, ST_SUM, ST_SQRT, ST_VINIT, ST_VEC, ST_SMUL, ST_SK, ST_SSUM, ST_DONE
   } gfl_state_type;

   // Floor of atan(2^-i) in Q30.
   function automatic logic [30:0] atan_q30(input logic [5:0] i);
      logic [30:0] v;
      begin
         case (i)
            6'd0: v = 31'h3243F6A8;
            6'd1: v = 31'h1DAC6705;
            6'd2: v = 31'h0FADBAFC;
            6'd3: v = 31'h07F56EA6;
            6'd4: v = 31'h03FEAB76;
            6'd5: v = 31'h01FFD55B;
            6'd6: v = 31'h00FFFAAA;
            6'd7: v = 31'h007FFF55;
            6'd8: v = 31'h003FFFEA;
            6'd9: v = 31'h001FFFFD;
            default: begin
               if (i <= 6'd30) begin
                  v = (31'd1 << (6'd30 - i)) - 31'd1;
               end else begin
                  v = '0;
               end
            end
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gfl_front.sv =====
// Front end: accepts requests, keeps the home and last-fix state and issues jobs.
// Depends on gfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfl_front import gfl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_kind,
   input  wire logic signed [30:0] req_latitude,
   input  wire logic signed [31:0] req_longitude,
   input  wire logic               queue_full,
   output logic                    push,
   output gfl_job_type             job
);

   logic signed [COORD_W-1:0] home_lat_ff, home_lat_in;
   logic signed [COORD_W-1:0] home_lon_ff, home_lon_in;
   logic signed [COORD_W-1:0] last_lat_ff, last_lat_in;
   logic signed [COORD_W-1:0] last_lon_ff, last_lon_in;
   logic                      latched_ff, latched_in;
   logic signed [COORD_W-1:0] lat;
   logic signed [COORD_W-1:0] lon;

   assign push = req_valid && !queue_full;
   assign lat  = COORD_W'(req_latitude);
   assign lon  = req_longitude;

   always_comb begin
      home_lat_in = home_lat_ff;
      home_lon_in = home_lon_ff;
      last_lat_in = last_lat_ff;
      last_lon_in = last_lon_ff;
      latched_in  = latched_ff;
      job.fix      = 1'b0;
      job.changed  = 1'b0;
      job.lat      = lat;
      job.lon      = lon;
      case (req_kind)
         KIND_FIX: begin
            job.fix = 1'b1;
            // The first fix after reset becomes home.
            if (!latched_ff) begin
               home_lat_in = lat;
               home_lon_in = lon;
               latched_in  = 1'b1;
               job.changed = 1'b1;
            end
            last_lat_in = lat;
            last_lon_in = lon;
         end
         KIND_HOME_GIVEN: begin
            home_lat_in = lat;
            home_lon_in = lon;
            job.changed = 1'b1;
         end
         KIND_HOME_LAST: begin
            home_lat_in = last_lat_ff;
            home_lon_in = last_lon_ff;
            job.changed = 1'b1;
         end
         default: begin
         end
      endcase
      job.home_lat = home_lat_in;
      job.home_lon = home_lon_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_lat_ff <= '0;
         home_lon_ff <= '0;
         last_lat_ff <= '0;
         last_lon_ff <= '0;
         latched_ff  <= 1'b0;
      end else if (push) begin
         home_lat_ff <= home_lat_in;
         home_lon_ff <= home_lon_in;
         last_lat_ff <= last_lat_in;
         last_lon_ff <= last_lon_in;
         latched_ff  <= latched_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gfl_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on gfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfl_queue import gfl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  gfl_job_type      push_job,
   input  wire logic        pop,
   output gfl_job_type      head_job,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   gfl_job_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gfl_back.sv =====
// Back end: sequences the three haversine evaluations of a fix through shared
// CORDIC, divider, square root and scaling units, and holds the response register.
// Depends on gfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfl_back import gfl_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [RADIUS_W-1:0] radius,
   input  gfl_job_type              head_job,
   input  wire logic                empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [34:0]              rsp_distance_mm,
   output logic signed [35:0]       rsp_east_mm,
   output logic signed [35:0]       rsp_north_mm,
   output logic                     rsp_home_changed
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

   gfl_state_type state_ff, state_in;

   logic [1:0]        pass_ff;
   logic [1:0]        ang_ff;
   logic [1:0]        prod_ff;
   logic              sqr_ff;
   logic [4:0]        cnt_ff;
   logic [STEP_W-1:0] step_ff;

   gfl_job_type job_ff;

   logic signed [34:0] a_ff;
   logic [30:0]        m_ff;
   logic               neg_ff;
   logic               sgn_ff;
   logic [52:0]        num_ff;
   logic [23:0]        rem_ff;
   logic [30:0]        quo_ff;
   logic signed [32:0] x_ff, y_ff, z_ff;
   logic signed [31:0] s1_ff, s2_ff, ca_ff, cb_ff;
   logic signed [31:0] p1_ff, p2_ff, p3_ff;
   logic [30:0]        ha_ff;
   logic [63:0]        sq_n_ff, sq_res_ff, sq_bit_ff;
   logic [30:0]        sy_ff;
   logic signed [33:0] vx_ff, vy_ff, vz_ff;
   logic [54:0]        t_ff;
   logic [34:0]        hk_ff;
   logic [9:0]         lk_ff;
   logic [34:0]        dist_ff, e_ff, n_ff;
   logic               rsp_valid_ff;
   logic               load_rsp;

   // Angle selection for the current pass and angle slot.
   logic signed [34:0] lat0, lon0, lat1, lon1, h;
   logic signed [34:0] wrapped, folded;
   logic               fold_neg;

   always_comb begin
      lat0 = 35'(job_ff.home_lat);
      lon0 = 35'(job_ff.home_lon);
      lat1 = (pass_ff == 2'd1) ? lat0 : 35'(job_ff.lat);
      lon1 = (pass_ff == 2'd2) ? lon0 : 35'(job_ff.lon);
      case (ang_ff)
         2'd0:    h = lat1 - lat0;
         2'd1:    h = lon1 - lon0;
         2'd2:    h = lat0 <<< 1;
         default: h = lat1 <<< 1;
      endcase
      if (h >= HALF_TURN) begin
         wrapped = h - FULL_TURN;
      end else if (h < -HALF_TURN) begin
         wrapped = h + FULL_TURN;
      end else begin
         wrapped = h;
      end
      fold_neg = 1'b0;
      if (a_ff > QUARTER_TURN) begin
         folded   = HALF_TURN - a_ff;
         fold_neg = 1'b1;
      end else if (a_ff < -QUARTER_TURN) begin
         folded   = -HALF_TURN - a_ff;
         fold_neg = 1'b1;
      end else begin
         folded = a_ff;
      end
   end

   // Division by the quarter turn. The numerator drops its low nine bits and is
   // divided by the odd factor through a reciprocal estimate that falls short by
   // at most two, which the remainder then corrects.
   logic [61:0] num_full;
   logic [63:0] est_p;
   logic [52:0] qe_p;
   logic [52:0] rem_full;
   logic [30:0] quo_fix;

   assign num_full = m_ff * HALF_PI_Q30 + ROUND_HALF;
   assign est_p    = num_ff[52:21] * QUARTER_RECIP;
   assign qe_p     = quo_ff * QUARTER_ODD;
   assign rem_full = num_ff - qe_p;

   always_comb begin
      if (rem_ff >= {QUARTER_ODD, 1'b0}) begin
         quo_fix = quo_ff + 31'd2;
      end else if (rem_ff >= QUARTER_ODD) begin
         quo_fix = quo_ff + 31'd1;
      end else begin
         quo_fix = quo_ff;
      end
   end

   // Rotation CORDIC step.
   logic signed [32:0] rot_at;
   logic signed [32:0] rot_xs;
   assign rot_at = $signed({2'b00, atan_q30(6'(step_ff))});
   assign rot_xs = neg_ff ? -x_ff : x_ff;

   // Shared signed multiplier for the haversine term.
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   always_comb begin
      case (prod_ff)
         2'd0: begin
            mul_a = s1_ff;
            mul_b = s1_ff;
         end
         2'd1: begin
            mul_a = ca_ff;
            mul_b = cb_ff;
         end
         2'd2: begin
            mul_a = s2_ff;
            mul_b = s2_ff;
         end
         default: begin
            mul_a = p2_ff;
            mul_b = p3_ff;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   logic signed [32:0] hav_sum;
   logic [30:0]        hav_a;
   always_comb begin
      hav_sum = 33'(p1_ff) + 33'(p2_ff);
      if (hav_sum < 0) begin
         hav_a = '0;
      end else if (hav_sum > $signed({2'b00, Q30_ONE})) begin
         hav_a = Q30_ONE;
      end else begin
         hav_a = hav_sum[30:0];
      end
   end

   // Square root step, one result bit per cycle.
   logic [63:0] sq_sum, sq_res_next;
   logic        sq_ge;
   logic [30:0] one_minus_a;
   assign sq_sum      = sq_res_ff + sq_bit_ff;
   assign sq_ge       = sq_n_ff >= sq_sum;
   assign sq_res_next = sq_ge ? (sq_res_ff >> 1) + sq_bit_ff : sq_res_ff >> 1;
   assign one_minus_a = Q30_ONE - ha_ff;

   // Vectoring CORDIC step.
   logic signed [33:0] vec_at;
   logic               vy_pos;
   assign vec_at = $signed({3'b000, atan_q30(6'(step_ff))});
   assign vy_pos = !vy_ff[33] && (vy_ff != '0);

   logic [30:0] z_clamp;
   always_comb begin
      if (vz_ff < 0) begin
         z_clamp = '0;
      end else if (vz_ff > $signed({3'b000, HALF_PI_Q30})) begin
         z_clamp = HALF_PI_Q30;
      end else begin
         z_clamp = vz_ff[30:0];
      end
   end

   logic [39:0] lo_scaled;
   logic [35:0] mm_sum;
   logic [34:0] mm_sat;
   assign lo_scaled = t_ff[29:0] * 40'd1000 + 40'd536870912;
   assign mm_sum    = {1'b0, hk_ff} + 36'(lk_ff);
   assign mm_sat    = (mm_sum > 36'(MAX_MM)) ? MAX_MM : mm_sum[34:0];

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Next state.
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               state_in = head_job.fix ? ST_WRAP : ST_DONE;
            end
         end
         ST_WRAP:  state_in = ST_FOLD;
         ST_FOLD:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_DIV;
         ST_DIV:   state_in = (cnt_ff == 5'd2) ? ST_RINIT : ST_DIV;
         ST_RINIT: state_in = ST_ROT;
         ST_ROT:   state_in = (step_ff == STEP_LAST) ? ST_REND : ST_ROT;
         ST_REND:  state_in = (ang_ff == 2'd3) ? ST_PROD : ST_WRAP;
         ST_PROD:  state_in = (prod_ff == 2'd3) ? ST_SUM : ST_PROD;
         ST_SUM:   state_in = ST_SQRT;
         ST_SQRT:  state_in = (cnt_ff == 5'd31 && sqr_ff) ? ST_VINIT : ST_SQRT;
         ST_VINIT: state_in = ST_VEC;
         ST_VEC:   state_in = (step_ff == STEP_LAST) ? ST_SMUL : ST_VEC;
         ST_SMUL:  state_in = ST_SK;
         ST_SK:    state_in = ST_SSUM;
         ST_SSUM:  state_in = (pass_ff == 2'd2) ? ST_DONE : ST_WRAP;
         ST_DONE:  state_in = load_rsp ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            job_ff  <= head_job;
            pass_ff <= 2'd0;
            ang_ff  <= 2'd0;
            dist_ff <= '0;
            e_ff    <= '0;
            n_ff    <= '0;
         end
         ST_WRAP: begin
            a_ff <= wrapped;
         end
         ST_FOLD: begin
            neg_ff <= fold_neg;
            sgn_ff <= folded[34];
            m_ff   <= folded[34] ? 31'(-folded) : folded[30:0];
         end
         ST_MUL: begin
            num_ff <= num_full[61:9];
            cnt_ff <= '0;
         end
         ST_DIV: begin
            case (cnt_ff)
               5'd0:    quo_ff <= est_p[62:32];
               5'd1:    rem_ff <= rem_full[23:0];
               default: quo_ff <= quo_fix;
            endcase
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_RINIT: begin
            x_ff    <= CORDIC_GAIN;
            y_ff    <= '0;
            z_ff    <= sgn_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
            step_ff <= '0;
         end
         ST_ROT: begin
            if (!z_ff[32]) begin
               x_ff <= x_ff - (y_ff >>> step_ff);
               y_ff <= y_ff + (x_ff >>> step_ff);
               z_ff <= z_ff - rot_at;
            end else begin
               x_ff <= x_ff + (y_ff >>> step_ff);
               y_ff <= y_ff - (x_ff >>> step_ff);
               z_ff <= z_ff + rot_at;
            end
            step_ff <= step_ff + 1'b1;
         end
         ST_REND: begin
            case (ang_ff)
               2'd0:    s1_ff <= 32'(y_ff);
               2'd1:    s2_ff <= 32'(y_ff);
               2'd2:    ca_ff <= 32'(rot_xs);
               default: cb_ff <= 32'(rot_xs);
            endcase
            ang_ff  <= ang_ff + 1'b1;
            prod_ff <= 2'd0;
         end
         ST_PROD: begin
            case (prod_ff)
               2'd0:    p1_ff <= mul_p[61:30];
               2'd2:    p3_ff <= mul_p[61:30];
               default: p2_ff <= mul_p[61:30];
            endcase
            prod_ff <= prod_ff + 1'b1;
         end
         ST_SUM: begin
            ha_ff     <= hav_a;
            sq_n_ff   <= {3'b000, hav_a, 30'b0};
            sq_res_ff <= '0;
            sq_bit_ff <= 64'd1 << 62;
            sqr_ff    <= 1'b0;
            cnt_ff    <= '0;
         end
         ST_SQRT: begin
            if (cnt_ff == 5'd31) begin
               // First root is sqrt(a); the second, sqrt(1 - a), starts right away.
               if (!sqr_ff) begin
                  sy_ff <= sq_res_next[30:0];
               end else begin
                  vx_ff <= $signed({3'b000, sq_res_next[30:0]});
               end
               sq_n_ff   <= {3'b000, one_minus_a, 30'b0};
               sq_res_ff <= '0;
               sq_bit_ff <= 64'd1 << 62;
               sqr_ff    <= 1'b1;
            end else begin
               sq_n_ff   <= sq_ge ? sq_n_ff - sq_sum : sq_n_ff;
               sq_res_ff <= sq_res_next;
               sq_bit_ff <= sq_bit_ff >> 2;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_VINIT: begin
            vy_ff   <= $signed({3'b000, sy_ff});
            vz_ff   <= '0;
            step_ff <= '0;
         end
         ST_VEC: begin
            if (vy_pos) begin
               vx_ff <= vx_ff + (vy_ff >>> step_ff);
               vy_ff <= vy_ff - (vx_ff >>> step_ff);
               vz_ff <= vz_ff + vec_at;
            end else begin
               vx_ff <= vx_ff - (vy_ff >>> step_ff);
               vy_ff <= vy_ff + (vx_ff >>> step_ff);
               vz_ff <= vz_ff - vec_at;
            end
            step_ff <= step_ff + 1'b1;
         end
         ST_SMUL: begin
            t_ff <= radius * {z_clamp, 1'b0};
         end
         ST_SK: begin
            hk_ff <= t_ff[54:30] * 35'd1000;
            lk_ff <= lo_scaled[39:30];
         end
         ST_SSUM: begin
            case (pass_ff)
               2'd0:    dist_ff <= mm_sat;
               2'd1:    e_ff    <= mm_sat;
               default: n_ff    <= mm_sat;
            endcase
            pass_ff <= pass_ff + 1'b1;
            ang_ff  <= 2'd0;
         end
         default: begin
         end
      endcase
   end

   // Response register; a new result loads while the previous one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_distance_mm  <= dist_ff;
         rsp_east_mm      <= (job_ff.home_lon > job_ff.lon) ?
                             -$signed({1'b0, e_ff}) : $signed({1'b0, e_ff});
         rsp_north_mm     <= (job_ff.home_lat > job_ff.lat) ?
                             -$signed({1'b0, n_ff}) : $signed({1'b0, n_ff});
         rsp_home_changed <= job_ff.changed;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gps_fix_to_local_metric_core.sv =====
// GPS fix to local metric core: turns fixes in 1e-7 degree into haversine distance and
// east/north offsets in millimetres from a home point. Top level; uses gfl_pkg and all gfl_ modules.
// In the back end a fix runs three haversine passes, each with four sine/cosine evaluations
// through one shared rotation CORDIC fed by a reciprocal radian divider, two bit-serial
// square roots and a vectoring CORDIC. Home commands and unused kinds skip these steps
// and go straight to the response register. A two-entry job queue lets the front end accept
// requests while the back end works, and the response register lets the back end finish a
// transaction while the previous result is still stalled.
// The earth radius register must only be written while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module gps_fix_to_local_metric_core import gfl_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [RADIUS_W-1:0] csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   input  wire logic signed [30:0]  req_latitude,
   input  wire logic signed [31:0]  req_longitude,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [34:0]              rsp_distance_mm,
   output logic signed [35:0]       rsp_east_mm,
   output logic signed [35:0]       rsp_north_mm,
   output logic                     rsp_home_changed
);

   logic [RADIUS_W-1:0] radius_ff;
   gfl_job_type         push_job;
   gfl_job_type         head_job;
   logic                push;
   logic                pop;
   logic                empty;
   logic                full;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   assign req_stall = full;

   gfl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_kind      (req_kind),
      .req_latitude  (req_latitude),
      .req_longitude (req_longitude),
      .queue_full    (full),
      .push          (push),
      .job           (push_job)
   );

   gfl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   gfl_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .radius           (radius_ff),
      .head_job         (head_job),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_distance_mm  (rsp_distance_mm),
      .rsp_east_mm      (rsp_east_mm),
      .rsp_north_mm     (rsp_north_mm),
      .rsp_home_changed (rsp_home_changed)
   );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for gps_fix_to_local_metric_core: queue-fed driver, checking monitor
// and a bit-exact haversine predictor. Depends on gfl_pkg and the RTL core only.
`timescale 1ns / 1ps

module tb;
   import gfl_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int STEPS = CORDIC_STEPS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 4000;
   localparam longint TURN_FULL = 64'sd7200000000;
   localparam longint TURN_HALF = 64'sd3600000000;
   localparam longint TURN_QUARTER = 64'sd1800000000;
   localparam longint PI_HALF_Q30 = 64'sd1686629713;
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint MM_LIMIT = 64'sd21990232555;
   localparam longint ARCTAN_HEAD [10] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD};

   typedef struct {
      logic [1:0]         kind;
      logic signed [30:0] lat;
      logic signed [31:0] lon;
   } fix_item_type;

   typedef struct {
      logic [34:0]        distance;
      logic signed [35:0] east;
      logic signed [35:0] north;
      logic               changed;
   } offset_type;

   logic clock, reset;
   logic csr_wr_en;
   logic [RADIUS_W-1:0] csr_wr_data;
   logic req_valid, req_stall;
   logic [1:0] req_kind;
   logic signed [30:0] req_latitude;
   logic signed [31:0] req_longitude;
   logic rsp_valid, rsp_stall;
   logic [34:0] rsp_distance_mm;
   logic signed [35:0] rsp_east_mm, rsp_north_mm;
   logic rsp_home_changed;

   gps_fix_to_local_metric_core i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_latitude(req_latitude), .req_longitude(req_longitude),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_distance_mm(rsp_distance_mm), .rsp_east_mm(rsp_east_mm),
      .rsp_north_mm(rsp_north_mm), .rsp_home_changed(rsp_home_changed));

   // Predictor state.
   longint radius_m;
   longint home_lat_q, home_lon_q, last_lat_q, last_lon_q;
   bit home_set;

   fix_item_type pending_items[$];
   offset_type expected_offsets[$];
   int errors, fixes_sent, homes_sent, unused_sent, results_seen, radius_settings;
   bit idle_enable, long_hold_pending;
   int idle_cycles;

   function automatic longint arctan_q30(input int i);
      if (i < 10) return ARCTAN_HEAD[i];
      if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
      return 0;
   endfunction

   // Angle h in units of 5e-8 degree.
   function automatic void sin_cos(input longint h, output longint s, output longint c);
      longint a, m, r, x, y, z, dx, dy;
      bit neg;
      a = h % TURN_FULL;
      neg = 0;
      x = 64'sd652032874;
      y = 0;
      if (a >= TURN_HALF) a -= TURN_FULL;
      if (a < -TURN_HALF) a += TURN_FULL;
      if (a > TURN_QUARTER) begin
         a = TURN_HALF - a;
         neg = 1;
      end else if (a < -TURN_QUARTER) begin
         a = -TURN_HALF - a;
         neg = 1;
      end
      m = (a < 0) ? -a : a;
      r = (m * PI_HALF_Q30 + TURN_QUARTER / 2) / TURN_QUARTER;
      z = (a < 0) ? -r : r;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_q30(i);
         end else begin
            x += dx; y -= dy; z += arctan_q30(i);
         end
      end
      s = y;
      c = neg ? -x : x;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint great_circle_mm(input longint lat0, lon0, lat1, lon1);
      longint s1, c1, s2, c2, sa, ca, sb, cb, a, x, y, z, nx, ny;
      longint unsigned t, mm;
      sin_cos(lat1 - lat0, s1, c1);
      sin_cos(lon1 - lon0, s2, c2);
      sin_cos(2 * lat0, sa, ca);
      sin_cos(2 * lat1, sb, cb);
      a = ((s1 * s1) >>> 30) + ((((ca * cb) >>> 30) * ((s2 * s2) >>> 30)) >>> 30);
      if (a < 0) a = 0;
      if (a > ONE_Q30) a = ONE_Q30;
      y = longint'(int_sqrt(longint'(a) << 30));
      x = longint'(int_sqrt(longint'(ONE_Q30 - a) << 30));
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_q30(i);
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_q30(i);
         end
         x = nx;
         y = ny;
      end
      if (z < 0) z = 0;
      if (z > PI_HALF_Q30) z = PI_HALF_Q30;
      t = longint'(radius_m) * (2 * z);
      mm = (t >> 30) * 1000 + (((t & 64'h3FFFFFFF) * 1000 + 64'h20000000) >> 30);
      return (mm > MM_LIMIT) ? MM_LIMIT : longint'(mm);
   endfunction

   function automatic offset_type predict_offsets(input fix_item_type it);
      offset_type r;
      longint lat, lon, e, n;
      lat = it.lat;
      lon = it.lon;
      r = '{distance: '0, east: '0, north: '0, changed: 1'b0};
      case (it.kind)
         KIND_FIX: begin
            if (!home_set) begin
               home_lat_q = lat;
               home_lon_q = lon;
               home_set = 1;
               r.changed = 1;
            end
            r.distance = 35'(great_circle_mm(home_lat_q, home_lon_q, lat, lon));
            e = great_circle_mm(home_lat_q, home_lon_q, home_lat_q, lon);
            n = great_circle_mm(home_lat_q, home_lon_q, lat, home_lon_q);
            r.east = 36'((home_lon_q > lon) ? -e : e);
            r.north = 36'((home_lat_q > lat) ? -n : n);
            last_lat_q = lat;
            last_lon_q = lon;
         end
         KIND_HOME_GIVEN: begin
            home_lat_q = lat;
            home_lon_q = lon;
            r.changed = 1;
         end
         KIND_HOME_LAST: begin
            home_lat_q = last_lat_q;
            home_lon_q = last_lon_q;
            r.changed = 1;
         end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Driver: offers queued items, with random gaps while idling is enabled.
   int send_gap;
   always @(posedge clock) begin
      fix_item_type it;
      if (reset) begin
         req_valid <= 0;
         req_kind <= '0;
         req_latitude <= '0;
         req_longitude <= '0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            it = '{kind: req_kind, lat: req_latitude, lon: req_longitude};
            expected_offsets.push_back(predict_offsets(it));
            idle_cycles = 0;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 0;
            end else if (pending_items.size() > 0) begin
               it = pending_items.pop_front();
               req_valid <= 1;
               req_kind <= it.kind;
               req_latitude <= it.lat;
               req_longitude <= it.lon;
               if (idle_enable && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Monitor: random stall bursts, one long hold-off on request, and the result check.
   int stall_left;
   always @(posedge clock) begin
      offset_type exp_r;
      if (reset) begin
         rsp_stall <= 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            results_seen++;
            if (expected_offsets.size() == 0) begin
               $display("%0t: unexpected transaction dist=%0d east=%0d north=%0d chg=%0b",
                        $time, rsp_distance_mm, rsp_east_mm, rsp_north_mm, rsp_home_changed);
               errors++;
            end else begin
               exp_r = expected_offsets.pop_front();
               if (rsp_distance_mm !== exp_r.distance) begin
                  $display("%0t: distance_mm expected %0d actual %0d",
                           $time, exp_r.distance, rsp_distance_mm);
                  errors++;
               end
               if (rsp_east_mm !== exp_r.east) begin
                  $display("%0t: east_mm expected %0d actual %0d", $time, exp_r.east, rsp_east_mm);
                  errors++;
               end
               if (rsp_north_mm !== exp_r.north) begin
                  $display("%0t: north_mm expected %0d actual %0d",
                           $time, exp_r.north, rsp_north_mm);
                  errors++;
               end
               if (rsp_home_changed !== exp_r.changed) begin
                  $display("%0t: home_changed expected %0b actual %0b",
                           $time, exp_r.changed, rsp_home_changed);
                  errors++;
               end
            end
         end
         if (long_hold_pending) begin
            long_hold_pending = 0;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && idle_enable && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_offsets.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic void add_item(input logic [1:0] k, input longint lat, input longint lon);
      pending_items.push_back('{kind: k, lat: 31'(lat), lon: 32'(lon)});
      if (k == KIND_FIX) fixes_sent++;
      else if (k == KIND_UNUSED) unused_sent++;
      else homes_sent++;
   endfunction

   function automatic void add_random_items(input int count);
      longint hl, hn;
      int pick;
      hl = $urandom_range(0, 1800000) * 500 - 450000000;
      hn = longint'($signed($urandom())) / 2;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            // Mostly fixes around a local home, some anywhere, some with raw bit patterns.
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5:
                  add_item(KIND_FIX, hl + $signed($urandom_range(0, 2000000)) - 1000000,
                           hn + $signed($urandom_range(0, 2000000)) - 1000000);
               6, 7:
                  add_item(KIND_FIX, longint'($urandom_range(0, 1800000000)) - 900000000,
                           longint'($signed($urandom())));
               default:
                  add_item(KIND_FIX, longint'($urandom()), longint'($urandom()));
            endcase
         end else if (pick < 78) begin
            if ($urandom_range(0, 3) == 0) begin
               hl = longint'($signed(31'($urandom())));
               hn = longint'($signed($urandom()));
            end else begin
               hl = longint'($urandom_range(0, 1800000000)) - 900000000;
               hn = longint'($signed($urandom())) / 2;
            end
            add_item(KIND_HOME_GIVEN, hl, hn);
         end else if (pick < 93) begin
            add_item(KIND_HOME_LAST, longint'($urandom()), longint'($urandom()));
         end else begin
            add_item(KIND_UNUSED, longint'($urandom()), longint'($urandom()));
         end
      end
   endfunction

   task automatic drain_and_set_radius(input longint r);
      do @(posedge clock); while (pending_items.size() != 0 || req_valid
                                  || expected_offsets.size() != 0);
      repeat (10) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= RADIUS_W'(r);
      radius_m = r;
      radius_settings++;
      @(posedge clock);
      csr_wr_en <= 0;
      idle_cycles = 0;
   endtask

   initial begin
      reset = 1;
      csr_wr_en = 0;
      csr_wr_data = '0;
      radius_m = 6371000;
      home_lat_q = 0;
      home_lon_q = 0;
      last_lat_q = 0;
      last_lon_q = 0;
      home_set = 0;
      idle_enable = 1;
      long_hold_pending = 0;
      idle_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // Directed: home commands before any fix, first-fix latching, extremes, wrap-around.
      add_item(KIND_HOME_LAST, -1, -1);
      add_item(KIND_HOME_GIVEN, 450000000, 100000000);
      add_item(KIND_UNUSED, -1, -1);
      add_item(KIND_FIX, 473977000, 85456000);
      add_item(KIND_FIX, 473977000, 85456000);
      add_item(KIND_FIX, 473987000, 85466000);
      add_item(KIND_FIX, 473967000, 85446000);
      add_item(KIND_FIX, 900000000, 1800000000);
      add_item(KIND_FIX, -900000000, -1800000000);
      add_item(KIND_FIX, 1073741823, 2147483647);
      add_item(KIND_FIX, -1073741824, -2147483648);
      add_item(KIND_HOME_GIVEN, 0, 0);
      add_item(KIND_FIX, 0, 1800000000);
      add_item(KIND_FIX, 0, -1799999999);
      add_item(KIND_HOME_LAST, 0, 0);
      add_item(KIND_FIX, -1, -1);
      add_item(KIND_HOME_GIVEN, -1073741824, 2147483647);
      add_item(KIND_FIX, 1073741823, -2147483648);
      add_item(KIND_UNUSED, 0, 0);
      add_item(KIND_FIX, 123456789, -987654321);

      drain_and_set_radius(7000000);
      add_random_items(450);
      drain_and_set_radius(6000000);
      long_hold_pending = 1;
      add_random_items(450);
      drain_and_set_radius(8388607);
      add_random_items(250);
      drain_and_set_radius(0);
      add_random_items(100);
      drain_and_set_radius(6371000);
      idle_enable = 0;
      add_random_items(600);

      do @(posedge clock); while (pending_items.size() != 0 || req_valid
                                  || expected_offsets.size() != 0);
      repeat (20) @(posedge clock);
      $display("Covered %0d fixes, %0d home commands and %0d unused kinds over %0d radii.",
               fixes_sent, homes_sent, unused_sent, radius_settings + 1);
      $display("%0d results checked, %0d mismatches.", results_seen, errors);
      if (errors == 0 && expected_offsets.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/gfl_pkg.sv
rtl/core/gfl_front.sv
rtl/core/gfl_queue.sv
rtl/core/gfl_back.sv
rtl/core/gps_fix_to_local_metric_core.sv
dv/tb.sv
